FILE: design/alu16_with_status_flags_macros.svh
// Assertion macros for the 16-bit ALU block.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef ALU16_WITH_STATUS_FLAGS_MACROS_SVH
`define ALU16_WITH_STATUS_FLAGS_MACROS_SVH

// Same-cycle implication.
`define ALU16_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ALU16_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/alu16_pkg.sv
// Shared types and constants for the 16-bit ALU block.
// No dependencies.
package alu16_pkg;

  localparam int DW = 16;

  typedef enum logic [3:0] {
    OP_MOV  = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_MUL  = 4'd3,
    OP_DIV  = 4'd4,
    OP_CMP  = 4'd5,
    OP_NOT  = 4'd6,
    OP_AND  = 4'd7,
    OP_OR   = 4'd8,
    OP_XOR  = 4'd9,
    OP_TEST = 4'd10,
    OP_SHL  = 4'd11,
    OP_SHR  = 4'd12
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  // iteration count: 16 for mul/div, up to 17 for shifts
  localparam logic [4:0] ITER_STEPS = 5'd16;
  localparam logic [4:0] SHIFT_SAT  = 5'd17;

  typedef struct packed {
    logic load;
    logic step;
    logic fin;
  } ctrl_t;

  typedef struct packed {
    logic wb;
    logic c_en;
    logic c_val;
    logic o_en;
    logic o_val;
    logic dz;
  } flags_t;

endpackage

FILE: design/alu16_with_status_flags.sv
// 16-bit ALU with Z, N, C, O flags. Single-pass ops need no adder iterations,
// mul and div take 16 adder iterations, and shifts move one bit per cycle,
// min(count, 17) times. A new beat is taken only after the last one has
// finished; the next beat is taken while the last result waits.
// Synchronous active-low reset clears the sequencer, output valid and C/O.
module alu16_with_status_flags (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_op,
  input  logic signed [15:0] in_src_value,
  input  logic signed [15:0] in_dst_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_result_value,
  output logic               out_write_back,
  output logic               out_zero_flag,
  output logic               out_negative_flag,
  output logic               out_carry_out,
  output logic               out_overflow_out,
  output logic               out_divide_by_zero
);

`include "alu16_with_status_flags_macros.svh"

  alu16_pkg::ctrl_t  ctrl;
  alu16_pkg::flags_t flags;
  logic [15:0]       res_value;
  logic              out_free;
  logic              carry_flag_r, carry_flag_nxt;
  logic              overflow_flag_r, overflow_flag_nxt;
  logic              out_valid_r;
  logic [15:0]       res_r;
  logic              wb_r, dz_r;

  assign out_free = !out_valid_r || out_ready;

  alu16_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_src   (in_src_value),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  alu16_dp u_dp (
    .clk       (clk),
    .ctrl      (ctrl),
    .in_op     (in_op),
    .in_src    (in_src_value),
    .in_dst    (in_dst_value),
    .res_value (res_value),
    .flags     (flags)
  );

  assign carry_flag_nxt    = flags.c_en ? flags.c_val : carry_flag_r;
  assign overflow_flag_nxt = flags.o_en ? flags.o_val : overflow_flag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      carry_flag_r    <= 1'b0;
      overflow_flag_r <= 1'b0;
    end else if (ctrl.fin) begin
      out_valid_r     <= 1'b1;
      carry_flag_r    <= carry_flag_nxt;
      overflow_flag_r <= overflow_flag_nxt;
    end else if (out_ready) begin
      out_valid_r     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fin) begin
      res_r <= res_value;
      wb_r  <= flags.wb;
      dz_r  <= flags.dz;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_value   = res_r;
  assign out_write_back     = wb_r;
  assign out_zero_flag      = (res_r == 16'd0);
  assign out_negative_flag  = res_r[15];
  assign out_carry_out      = carry_flag_r;
  assign out_overflow_out   = overflow_flag_r;
  assign out_divide_by_zero = dz_r;

  // busy after every accepted beat
  `ALU16_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  // a result beat is only loaded when the output slot is free
  `ALU16_ASSERT_IMP(a_no_overwrite, ctrl.fin, !out_valid_r || out_ready, "result overwritten")
  // zero divisor gives a zero, written-back result
  `ALU16_ASSERT_IMP(a_div_zero, out_valid && out_divide_by_zero,
    out_zero_flag && out_write_back && !out_negative_flag, "bad div-by-zero result")
  // sequencer strobes are exclusive
  `ALU16_ASSERT_IMP(a_ctrl_onehot, 1'b1, $onehot0({ctrl.load, ctrl.step, ctrl.fin}), "ctrl overlap")

endmodule

FILE: design/alu16_seq.sv
// Sequencer for the 16-bit ALU: handshake, iteration counter, control strobes.
// Depends on alu16_pkg.
module alu16_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [3:0]        in_op,
  input  logic [15:0]       in_src,
  input  logic              out_free,
  output logic              in_ready,
  output alu16_pkg::ctrl_t  ctrl
);

  alu16_pkg::state_t state_r, state_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [4:0]        cnt_init;
  logic              accept;

  always_comb begin
    case (alu16_pkg::op_t'(in_op)) inside
      alu16_pkg::OP_MUL, alu16_pkg::OP_DIV: cnt_init = alu16_pkg::ITER_STEPS;
      alu16_pkg::OP_SHL, alu16_pkg::OP_SHR: begin
        if (in_src >= {11'd0, alu16_pkg::SHIFT_SAT}) begin
          cnt_init = alu16_pkg::SHIFT_SAT;
        end else begin
          cnt_init = in_src[4:0];
        end
      end
      default: cnt_init = 5'd0;
    endcase
  end

  assign in_ready = (state_r == alu16_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= alu16_pkg::ST_IDLE;
      cnt_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctrl      = '0;
    unique case (state_r)
      alu16_pkg::ST_IDLE: begin
        if (accept) begin
          ctrl.load = 1'b1;
          cnt_nxt   = cnt_init;
          state_nxt = (cnt_init != 5'd0) ? alu16_pkg::ST_RUN : alu16_pkg::ST_FIN;
        end
      end
      alu16_pkg::ST_RUN: begin
        ctrl.step = 1'b1;
        cnt_nxt   = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          state_nxt = alu16_pkg::ST_FIN;
        end
      end
      alu16_pkg::ST_FIN: begin
        if (out_free) begin
          ctrl.fin  = 1'b1;
          state_nxt = alu16_pkg::ST_IDLE;
        end
      end
      default: state_nxt = alu16_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: design/alu16_dp.sv
// Datapath for the 16-bit ALU: operand registers, one shared 18-bit adder,
// shift-add multiply, restoring divide, bit-serial shifts. Depends on alu16_pkg.
module alu16_dp (
  input  logic              clk,
  input  alu16_pkg::ctrl_t  ctrl,
  input  logic [3:0]        in_op,
  input  logic [15:0]       in_src,
  input  logic [15:0]       in_dst,
  output logic [15:0]       res_value,
  output alu16_pkg::flags_t flags
);

  alu16_pkg::op_t op_r;
  alu16_pkg::op_t op_in;
  logic [15:0] s_r, d_r, acc_r, m_r, q_r;
  logic [15:0] rem_r;
  logic        shz_r, sc_r;

  logic [16:0] add_a, add_b;
  logic        add_inv;
  logic [17:0] sum;
  logic [16:0] remsh;
  logic        geq;
  logic [15:0] smag, dmag;
  logic        neg_q;

  assign op_in = alu16_pkg::op_t'(in_op);
  assign smag  = in_src[15] ? (16'd0 - in_src) : in_src;
  assign dmag  = in_dst[15] ? (16'd0 - in_dst) : in_dst;
  assign remsh = {rem_r, q_r[15]};
  assign neg_q = d_r[15] ^ s_r[15];

  // shared adder: a + b, or a - b with bit 17 set when a >= b
  always_comb begin
    add_a   = 17'd0;
    add_b   = 17'd0;
    add_inv = 1'b0;
    if (ctrl.step) begin
      case (op_r)
        alu16_pkg::OP_MUL: begin
          add_a = {1'b0, acc_r};
          add_b = q_r[0] ? {1'b0, m_r} : 17'd0;
        end
        alu16_pkg::OP_DIV: begin
          add_a   = remsh;
          add_b   = {1'b0, m_r};
          add_inv = 1'b1;
        end
        default: ;
      endcase
    end else begin
      case (op_r) inside
        alu16_pkg::OP_ADD: begin
          add_a = {1'b0, d_r};
          add_b = {1'b0, s_r};
        end
        alu16_pkg::OP_SUB, alu16_pkg::OP_CMP: begin
          add_a   = {1'b0, d_r};
          add_b   = {1'b0, s_r};
          add_inv = 1'b1;
        end
        alu16_pkg::OP_DIV: begin
          add_b   = {1'b0, q_r};
          add_inv = 1'b1;
        end
        default: ;
      endcase
    end
    sum = {1'b0, add_a} + {1'b0, (add_inv ? ~add_b : add_b)} + {17'd0, add_inv};
  end

  assign geq = sum[17];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_r  <= op_in;
      s_r   <= in_src;
      d_r   <= in_dst;
      acc_r <= (op_in == alu16_pkg::OP_MUL) ? 16'd0 : in_dst;
      m_r   <= (op_in == alu16_pkg::OP_DIV) ? smag : in_dst;
      q_r   <= (op_in == alu16_pkg::OP_DIV) ? dmag : in_src;
      rem_r <= 16'd0;
      shz_r <= (in_src == 16'd0);
      sc_r  <= 1'b0;
    end else if (ctrl.step) begin
      case (op_r)
        alu16_pkg::OP_MUL: begin
          acc_r <= sum[15:0];
          m_r   <= {m_r[14:0], 1'b0};
          q_r   <= {1'b0, q_r[15:1]};
        end
        alu16_pkg::OP_DIV: begin
          rem_r <= geq ? sum[15:0] : remsh[15:0];
          q_r   <= {q_r[14:0], geq};
        end
        alu16_pkg::OP_SHL: begin
          sc_r  <= acc_r[15];
          acc_r <= {acc_r[14:0], 1'b0};
        end
        alu16_pkg::OP_SHR: begin
          sc_r  <= acc_r[0];
          acc_r <= {acc_r[15], acc_r[15:1]};
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_value = 16'd0;
    flags     = '0;
    flags.wb  = 1'b1;
    case (op_r) inside
      alu16_pkg::OP_MOV: res_value = s_r;
      alu16_pkg::OP_ADD: begin
        res_value   = sum[15:0];
        flags.c_en  = 1'b1;
        flags.c_val = sum[16];
        flags.o_en  = 1'b1;
        flags.o_val = ~(d_r[15] ^ s_r[15]) & (d_r[15] ^ sum[15]);
      end
      alu16_pkg::OP_SUB, alu16_pkg::OP_CMP: begin
        res_value   = sum[15:0];
        flags.wb    = (op_r != alu16_pkg::OP_CMP);
        flags.c_en  = 1'b1;
        flags.c_val = ~sum[17];
        flags.o_en  = 1'b1;
        flags.o_val = (d_r[15] ^ s_r[15]) & (d_r[15] ^ sum[15]);
      end
      alu16_pkg::OP_MUL: res_value = acc_r;
      alu16_pkg::OP_DIV: begin
        if (s_r == 16'd0) begin
          flags.dz = 1'b1;
        end else begin
          res_value = neg_q ? sum[15:0] : q_r;
        end
      end
      alu16_pkg::OP_NOT:  res_value = ~s_r;
      alu16_pkg::OP_AND:  res_value = d_r & s_r;
      alu16_pkg::OP_OR:   res_value = d_r | s_r;
      alu16_pkg::OP_XOR:  res_value = d_r ^ s_r;
      alu16_pkg::OP_TEST: begin
        res_value = d_r & s_r;
        flags.wb  = 1'b0;
      end
      alu16_pkg::OP_SHL, alu16_pkg::OP_SHR: begin
        res_value   = acc_r;
        flags.c_en  = ~shz_r;
        flags.c_val = sc_r;
      end
      default: flags.wb = 1'b0;
    endcase
  end

endmodule

FILE: dv/alu16_with_status_flags_checker.sv
// Scoreboard for the 16-bit ALU: predicts every result beat from the accepted
// input beats and compares it with the output channel. Uses alu16_pkg opcodes.
module alu16_with_status_flags_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  in_op,
  input  logic [15:0] in_src_value,
  input  logic [15:0] in_dst_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_result_value,
  input  logic        out_write_back,
  input  logic        out_zero_flag,
  input  logic        out_negative_flag,
  input  logic        out_carry_out,
  input  logic        out_overflow_out,
  input  logic        out_divide_by_zero,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic [15:0] value;
    logic        wb;
    logic        z;
    logic        n;
    logic        c;
    logic        o;
    logic        dz;
  } alu_res_t;

  alu_res_t alu_results_q[$];
  logic     carry_q = 1'b0;
  logic     ovf_q = 1'b0;
  int       err_cnt = 0;

  function automatic alu_res_t alu_predict(input logic [3:0] op, input logic [15:0] s,
                                           input logic [15:0] d, input logic c_in,
                                           input logic o_in);
    alu_res_t    res;
    logic [16:0] sum;
    logic [31:0] wide;
    logic [16:0] sh;
    logic [4:0]  cnt;
    int          dn;
    int          sn;
    int          quo;
    res = '0;
    res.wb = 1'b1;
    res.c = c_in;
    res.o = o_in;
    case (op) inside
      alu16_pkg::OP_MOV: res.value = s;
      alu16_pkg::OP_ADD: begin
        sum = {1'b0, d} + {1'b0, s};
        res.value = sum[15:0];
        res.c = sum[16];
        res.o = (d[15] == s[15]) && (sum[15] != d[15]);
      end
      alu16_pkg::OP_SUB, alu16_pkg::OP_CMP: begin
        res.value = d - s;
        res.c = d < s;
        res.o = (d[15] != s[15]) && (res.value[15] != d[15]);
        res.wb = (op != alu16_pkg::OP_CMP);
      end
      alu16_pkg::OP_MUL: res.value = d * s;
      alu16_pkg::OP_DIV: begin
        if (s == 16'd0) begin
          res.dz = 1'b1;
        end else begin
          dn = $signed(d);
          sn = $signed(s);
          quo = dn / sn;
          res.value = quo[15:0];
        end
      end
      alu16_pkg::OP_NOT: res.value = ~s;
      alu16_pkg::OP_AND: res.value = d & s;
      alu16_pkg::OP_OR:  res.value = d | s;
      alu16_pkg::OP_XOR: res.value = d ^ s;
      alu16_pkg::OP_TEST: begin
        res.value = d & s;
        res.wb = 1'b0;
      end
      alu16_pkg::OP_SHL: begin
        if (s == 16'd0) begin
          res.value = d;
        end else begin
          // bit 16 of the widened value is the last bit shifted out
          wide = {16'd0, d} << s;
          res.value = wide[15:0];
          res.c = wide[16];
        end
      end
      alu16_pkg::OP_SHR: begin
        if (s == 16'd0) begin
          res.value = d;
        end else begin
          // guard bit below the lsb catches the last bit shifted out
          cnt = (s >= 16'd16) ? 5'd16 : s[4:0];
          sh = $signed({d, 1'b0}) >>> cnt;
          res.value = sh[16:1];
          res.c = sh[0];
        end
      end
      default: res.wb = 1'b0;
    endcase
    res.z = (res.value == 16'd0);
    res.n = res.value[15];
    return res;
  endfunction

  always @(posedge clk) begin
    alu_res_t exp_r;
    alu_res_t got_r;
    if (!rst_n) begin
      alu_results_q.delete();
      carry_q = 1'b0;
      ovf_q = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        exp_r = alu_predict(in_op, in_src_value, in_dst_value, carry_q, ovf_q);
        carry_q = exp_r.c;
        ovf_q = exp_r.o;
        alu_results_q.push_back(exp_r);
      end
      if (out_valid && out_ready) begin
        got_r = {out_result_value, out_write_back, out_zero_flag, out_negative_flag,
                 out_carry_out, out_overflow_out, out_divide_by_zero};
        if (alu_results_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("ALU: result beat with nothing pending, value=%h", got_r.value);
        end else begin
          exp_r = alu_results_q.pop_front();
          if (got_r !== exp_r) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("ALU mismatch: exp val=%h wb=%b z=%b n=%b c=%b o=%b dz=%b",
                       exp_r.value, exp_r.wb, exp_r.z, exp_r.n, exp_r.c, exp_r.o, exp_r.dz,
                       " | got val=%h wb=%b z=%b n=%b c=%b o=%b dz=%b",
                       got_r.value, got_r.wb, got_r.z, got_r.n, got_r.c, got_r.o, got_r.dz);
          end
        end
      end
    end
    mismatches <= err_cnt;
    pending <= alu_results_q.size();
  end

endmodule

FILE: dv/alu16_with_status_flags_tb.sv
// Top of the 16-bit ALU testbench: clock, reset, input and result-side traffic,
// watchdog and verdict. Needs alu16_pkg, the ALU and alu16_with_status_flags_checker.
module alu16_with_status_flags_tb;

  localparam logic [3:0]  OP_SPARE_FIRST = 4'd13;
  localparam logic [3:0]  OP_SPARE_LAST  = 4'd15;
  localparam logic [15:0] V_MAX  = 16'h7FFF;
  localparam logic [15:0] V_MIN  = 16'h8000;
  localparam logic [15:0] V_ONES = 16'hFFFF;
  localparam int RANDOM_BEATS = 800;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 150;

  typedef enum {GAP_RANDOM, GAP_NONE, GAP_DRAIN} gap_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         in_op = 4'd0;
  logic signed [15:0] in_src_value = 16'sd0;
  logic signed [15:0] in_dst_value = 16'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_result_value;
  logic               out_write_back;
  logic               out_zero_flag;
  logic               out_negative_flag;
  logic               out_carry_out;
  logic               out_overflow_out;
  logic               out_divide_by_zero;
  int                 mismatches;
  int                 pending;
  int                 out_beats = 0;
  int                 idle_cycles = 0;

  alu16_with_status_flags uut (.*);

  alu16_with_status_flags_checker u_checker (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_operand();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0: return 16'd0;
        1: return 16'd1;
        2: return V_ONES;
        3: return V_MAX;
        default: return V_MIN;
      endcase
    end
    if (r == 1) return 16'($urandom_range(0, 3));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, 17));
    if (r < 85) return 16'($urandom_range(18, 40));
    return 16'($urandom);
  endfunction

  task automatic push_beat(input logic [3:0] op, input logic [15:0] s, input logic [15:0] d,
                           input gap_mode_t mode);
    int gap;
    in_valid <= 1'b1;
    in_op <= op;
    in_src_value <= s;
    in_dst_value <= d;
    do @(posedge clk); while (!in_ready);
    gap = (mode == GAP_RANDOM) ? pick_idle() : 0;
    if (gap > 0 || mode == GAP_DRAIN) in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
    if (mode == GAP_DRAIN) begin
      do @(posedge clk); while (pending != 0);
    end
  endtask

  // result side: random stalls plus two long hold-offs to back up the input
  initial begin
    int run_len;
    int stall_len;
    int holds_done;
    holds_done = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      if ((holds_done == 0 && out_beats >= 250) || (holds_done == 1 && out_beats >= 600)) begin
        stall_len = HOLD_CYCLES;
        holds_done++;
      end else begin
        stall_len = pick_idle();
      end
      if (stall_len > 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (out_valid && out_ready) out_beats <= out_beats + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [3:0]  op;
    logic [15:0] src;
    logic [15:0] dst;
    gap_mode_t   mode;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    push_beat(alu16_pkg::OP_MOV, V_MIN, 16'd0, GAP_RANDOM);
    push_beat(alu16_pkg::OP_ADD, 16'd1, V_MAX, GAP_RANDOM);
    push_beat(alu16_pkg::OP_ADD, 16'd1, V_ONES, GAP_RANDOM);
    push_beat(alu16_pkg::OP_ADD, V_MIN, V_MIN, GAP_RANDOM);
    push_beat(alu16_pkg::OP_SUB, 16'd1, 16'd0, GAP_RANDOM);
    push_beat(alu16_pkg::OP_SUB, 16'd1, V_MIN, GAP_RANDOM);
    push_beat(alu16_pkg::OP_CMP, V_MAX, V_MAX, GAP_RANDOM);
    push_beat(alu16_pkg::OP_MUL, V_MAX, V_MAX, GAP_RANDOM);
    push_beat(alu16_pkg::OP_MUL, V_ONES, 16'd3, GAP_RANDOM);
    push_beat(alu16_pkg::OP_DIV, 16'd0, V_MAX, GAP_RANDOM);
    push_beat(alu16_pkg::OP_DIV, V_ONES, V_MIN, GAP_RANDOM);
    push_beat(alu16_pkg::OP_DIV, 16'd2, 16'hFFF9, GAP_RANDOM);
    push_beat(alu16_pkg::OP_NOT, V_ONES, V_MAX, GAP_RANDOM);
    push_beat(alu16_pkg::OP_AND, 16'hF0F0, 16'hFF00, GAP_RANDOM);
    push_beat(alu16_pkg::OP_OR, 16'h0F0F, V_MIN, GAP_RANDOM);
    push_beat(alu16_pkg::OP_XOR, V_ONES, V_ONES, GAP_RANDOM);
    push_beat(alu16_pkg::OP_TEST, V_MIN, V_ONES, GAP_RANDOM);
    push_beat(alu16_pkg::OP_SHL, 16'd0, V_ONES, GAP_RANDOM);
    push_beat(alu16_pkg::OP_SHL, 16'd1, V_MIN, GAP_RANDOM);
    push_beat(alu16_pkg::OP_SHL, 16'd16, 16'd1, GAP_RANDOM);
    push_beat(alu16_pkg::OP_SHL, V_MIN, V_ONES, GAP_RANDOM);
    push_beat(alu16_pkg::OP_SHR, 16'd1, 16'h8001, GAP_RANDOM);
    push_beat(alu16_pkg::OP_SHR, 16'd16, V_MIN, GAP_RANDOM);
    push_beat(alu16_pkg::OP_SHR, V_ONES, V_MAX, GAP_RANDOM);
    for (int k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++)
      push_beat(4'(k), V_ONES, V_ONES, (k == OP_SPARE_LAST) ? GAP_DRAIN : GAP_RANDOM);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if ($urandom_range(0, 99) < 95) op = 4'($urandom_range(alu16_pkg::OP_MOV, alu16_pkg::OP_SHR));
      else op = 4'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      src = pick_operand();
      dst = pick_operand();
      if (op == alu16_pkg::OP_SHL || op == alu16_pkg::OP_SHR) src = pick_count();
      else if (op == alu16_pkg::OP_DIV && $urandom_range(0, 9) == 0) src = 16'd0;
      if (i == 400) mode = GAP_DRAIN;
      else if (i >= 150 && i < 230) mode = GAP_NONE;
      else mode = GAP_RANDOM;
      push_beat(op, src, dst, mode);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/alu16_pkg.sv
design/alu16_seq.sv
design/alu16_dp.sv
design/alu16_with_status_flags.sv
dv/alu16_with_status_flags_checker.sv
dv/alu16_with_status_flags_tb.sv
